// ===== design/pbv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbv_pkg: shared definitions for the packed bit vector engine
// Field widths, operation and status codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package pbv_pkg;

	// default sizing of the store
	localparam int CAPACITY_DEF  = 1024;
	localparam int WORD_BITS_DEF = 32;

	// item field widths
	localparam int MODE_W   = 3;
	localparam int POS_W    = 11;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [STATUS_W-1:0] status_t;

	// operation codes
	localparam mode_t MODE_APPEND = 3'd0;
	localparam mode_t MODE_INSERT = 3'd1;
	localparam mode_t MODE_WRITE  = 3'd2;
	localparam mode_t MODE_READ   = 3'd3;
	localparam mode_t MODE_ERASE  = 3'd4;

	// status codes
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_INVALID = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RMW,
		S_INS,
		S_ER_BASE,
		S_ER_PRIME,
		S_ER,
		S_DONE
	} state_t;

endpackage

// ===== design/packed_bit_vector_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_bit_vector_engine: packed bit store with running length
// Append, insert, write, read and range erase on a word-organized RAM.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid / in_ready    | mode, position, end_position, bit_value
//   out     | out_valid / out_ready  | read_bit, element_count, status
//
// Append, write and read step from accept (RAM read) through modify to the result.
// Insert and erase step through the RAM one word per cycle, over the span of
// words from the position to the end of the vector (up to CAPACITY/WORD_BITS);
// rejected items, empty erases and erases that reach the end of the vector
// go straight to the result without a RAM access.
// Reset clears the length; the RAM contents are not cleared.
// A new item is taken whenever the sequencer is idle, even while a result
// still waits in the output register. WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
module packed_bit_vector_engine #(
	parameter int CAPACITY  = pbv_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = pbv_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pbv_pkg::MODE_W-1:0]    mode,
	input  logic [pbv_pkg::POS_W-1:0]     position,
	input  logic [pbv_pkg::POS_W-1:0]     end_position,
	input  logic                          bit_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          read_bit,
	output logic [pbv_pkg::COUNT_W-1:0]   element_count,
	output logic [pbv_pkg::STATUS_W-1:0]  status
);

	import pbv_pkg::*;

	localparam int DEPTH = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LOG   = $clog2(WORD_BITS);
	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int CW    = (LEN_W > POS_W) ? LEN_W : POS_W;

	typedef logic [WORD_BITS-1:0] word_t;

	// control state
	state_t            state_q, state_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic              out_valid_q, out_valid_d;

	// item and datapath registers
	mode_t             mode_q, mode_d;
	logic [CW-1:0]     pos_q, pos_d;
	logic [CW-1:0]     tgt_q, tgt_d;
	logic [CW-1:0]     gap_q, gap_d;
	logic [CW-1:0]     ptr_q, ptr_d;
	logic [CW-1:0]     last_q, last_d;
	logic [CW-1:0]     src_q, src_d;
	logic [LOG-1:0]    sh_q, sh_d;
	logic              val_q, val_d;
	logic              carry_q, carry_d;
	logic              first_q, first_d;
	logic              rbit_q, rbit_d;
	status_t           st_q, st_d;
	word_t             base_q, base_d;
	word_t             prev_q, prev_d;

	// output register payload
	logic              read_bit_q, read_bit_d;
	logic [COUNT_W-1:0] count_q, count_d;
	status_t           status_q, status_d;

	// ram port
	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr, wr_addr;
	word_t             rd_data, wr_data;

	// helpers
	logic [CW-1:0]     pos_x, endp_x, len_x, gap_x, newlen_x;
	logic              full;
	logic [LOG-1:0]    bsel;
	word_t             bitm, lowm;
	word_t             pair;

	pbv_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// common-width views of the fields and length
	assign pos_x    = CW'(position);
	assign endp_x   = CW'(end_position);
	assign len_x    = CW'(len_q);
	assign gap_x    = endp_x - pos_x;
	assign newlen_x = len_x - gap_x;
	assign full     = (len_x >= CW'(CAPACITY));

	// bit masks within a word: the target bit for single-bit ops, else the position
	assign bsel = (state_q == S_RMW) ? tgt_q[LOG-1:0] : pos_q[LOG-1:0];
	assign bitm = word_t'(1) << bsel;
	assign lowm = bitm - word_t'(1);

	// funnel of two source words for erase
	assign pair = WORD_BITS'({rd_data, prev_q} >> sh_q);

	// sequencer: next state, ram controls and register updates
	always_comb begin
		state_d     = state_q;
		len_d       = len_q;
		out_valid_d = out_valid_q;
		mode_d      = mode_q;
		pos_d       = pos_q;
		tgt_d       = tgt_q;
		gap_d       = gap_q;
		ptr_d       = ptr_q;
		last_d      = last_q;
		src_d       = src_q;
		sh_d        = sh_q;
		val_d       = val_q;
		carry_d     = carry_q;
		first_d     = first_q;
		rbit_d      = rbit_q;
		st_d        = st_q;
		base_d      = base_q;
		prev_d      = prev_q;
		read_bit_d  = read_bit_q;
		count_d     = count_q;
		status_d    = status_q;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = '0;

		// output taken
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mode_d  = mode;
					pos_d   = pos_x;
					val_d   = bit_value;
					st_d    = ST_OK;
					rbit_d  = 1'b0;
					first_d = 1'b1;
					carry_d = 1'b0;
					gap_d   = gap_x;
					state_d = S_DONE;
					unique case (mode) inside
						MODE_APPEND: begin
							if (full) begin
								st_d = ST_FULL;
							end else begin
								tgt_d   = len_x;
								rd_en   = 1'b1;
								rd_addr = AW'(len_x >> LOG);
								state_d = S_RMW;
							end
						end
						MODE_INSERT: begin
							if (pos_x > len_x) begin
								st_d = ST_INVALID;
							end else if (full) begin
								st_d = ST_FULL;
							end else begin
								rd_en   = 1'b1;
								rd_addr = AW'(pos_x >> LOG);
								ptr_d   = pos_x >> LOG;
								last_d  = len_x >> LOG;
								state_d = S_INS;
							end
						end
						MODE_WRITE, MODE_READ: begin
							if (pos_x >= len_x) begin
								st_d = ST_INVALID;
							end else begin
								tgt_d   = pos_x;
								rd_en   = 1'b1;
								rd_addr = AW'(pos_x >> LOG);
								state_d = S_RMW;
							end
						end
						MODE_ERASE: begin
							if (pos_x > endp_x || endp_x > len_x) begin
								st_d = ST_INVALID;
							end else if (gap_x != '0 && endp_x < len_x) begin
								// read the first destination word, then stream sources
								rd_en   = 1'b1;
								rd_addr = AW'(pos_x >> LOG);
								ptr_d   = pos_x >> LOG;
								last_d  = (newlen_x - CW'(1)) >> LOG;
								src_d   = (pos_x >> LOG) + (gap_x >> LOG);
								sh_d    = gap_x[LOG-1:0];
								state_d = S_ER_BASE;
							end else begin
								// nothing moves: only the length is updated
								len_d = LEN_W'(newlen_x);
							end
						end
						default: begin
							st_d = ST_INVALID;
						end
					endcase
				end
			end

			S_RMW: begin
				if (mode_q == MODE_READ) begin
					rbit_d = rd_data[bsel];
				end else begin
					wr_en   = 1'b1;
					wr_addr = AW'(tgt_q >> LOG);
					wr_data = (rd_data & ~bitm) | (val_q ? bitm : '0);
					if (mode_q == MODE_APPEND) begin
						len_d = len_q + LEN_W'(1);
					end
				end
				state_d = S_DONE;
			end

			S_INS: begin
				// shift the word up by one, carrying the top bit of the previous word
				wr_en   = 1'b1;
				wr_addr = AW'(ptr_q);
				if (first_q) begin
					wr_data = (rd_data & lowm) | ((rd_data << 1) & ~(lowm | bitm))
						| (val_q ? bitm : '0);
				end else begin
					wr_data = (rd_data << 1) | word_t'(carry_q);
				end
				carry_d = rd_data[WORD_BITS-1];
				first_d = 1'b0;
				if (ptr_q == last_q) begin
					len_d   = len_q + LEN_W'(1);
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(ptr_q + CW'(1));
					ptr_d   = ptr_q + CW'(1);
				end
			end

			S_ER_BASE: begin
				base_d  = rd_data;
				rd_en   = 1'b1;
				rd_addr = (src_q >= CW'(DEPTH)) ? AW'(DEPTH - 1) : AW'(src_q);
				src_d   = src_q + CW'(1);
				state_d = S_ER_PRIME;
			end

			S_ER_PRIME: begin
				prev_d  = rd_data;
				rd_en   = 1'b1;
				rd_addr = (src_q >= CW'(DEPTH)) ? AW'(DEPTH - 1) : AW'(src_q);
				src_d   = src_q + CW'(1);
				state_d = S_ER;
			end

			S_ER: begin
				// destination word from two consecutive source words
				wr_en   = 1'b1;
				wr_addr = AW'(ptr_q);
				if (first_q) begin
					wr_data = (base_q & lowm) | (pair & ~lowm);
				end else begin
					wr_data = pair;
				end
				prev_d  = rd_data;
				first_d = 1'b0;
				if (ptr_q == last_q) begin
					len_d   = len_q - LEN_W'(gap_q);
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = (src_q >= CW'(DEPTH)) ? AW'(DEPTH - 1) : AW'(src_q);
					src_d   = src_q + CW'(1);
					ptr_d   = ptr_q + CW'(1);
				end
			end

			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					read_bit_d  = rbit_q;
					count_d     = COUNT_W'(len_q);
					status_d    = st_q;
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			len_q       <= len_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		mode_q     <= mode_d;
		pos_q      <= pos_d;
		tgt_q      <= tgt_d;
		gap_q      <= gap_d;
		ptr_q      <= ptr_d;
		last_q     <= last_d;
		src_q      <= src_d;
		sh_q       <= sh_d;
		val_q      <= val_d;
		carry_q    <= carry_d;
		first_q    <= first_d;
		rbit_q     <= rbit_d;
		st_q       <= st_d;
		base_q     <= base_d;
		prev_q     <= prev_d;
		read_bit_q <= read_bit_d;
		count_q    <= count_d;
		status_q   <= status_d;
	end

	// ports
	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign read_bit      = read_bit_q;
	assign element_count = count_q;
	assign status        = status_q;

endmodule

// ===== design/pbv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbv_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module pbv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
